@@ src/assert_macros.svh @@
// Assertion macros for the checker file of the gradient blend block (lgpb_checker.sv).
// Each macro expands to one labelled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset cycles included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lgpb_pkg.sv @@
// Shared widths, register indexes and payload structs for the gradient blend block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lgpb_pkg;

  localparam int POS_FRAC_BITS = 16;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  // Squared length is at most twice (2^16 - 1)^2, which needs one bit less than a product.
  localparam int LEN_W      = 2 * DIFF_W - 1;
  localparam int NUM_W      = 2 * DIFF_W;
  localparam int T_W        = POS_FRAC_BITS + 1;
  localparam int DVD_W      = LEN_W + T_W;
  localparam int GS_W       = T_W + 10;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 4 * CHAN_W;
  localparam int MIX_W      = 2 * CHAN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SETUP_STAGES = 4;
  localparam int BLEND_STAGES = 4;
  localparam int PIPE_DEPTH   = SETUP_STAGES + T_W + BLEND_STAGES;

  localparam logic [T_W-1:0]         T_ONE    = {1'b1, {POS_FRAC_BITS{1'b0}}};
  localparam logic signed [GS_W-1:0] G_HALF   =
    {{(GS_W - POS_FRAC_BITS){1'b0}}, 1'b1, {(POS_FRAC_BITS - 1){1'b0}}};
  localparam logic [CHAN_W-1:0]      CHAN_MAX = 8'd255;
  localparam logic [MIX_W-1:0]       MIX_BIAS = 16'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X    = 3'd0,
    REG_START_Y    = 3'd1,
    REG_END_X      = 3'd2,
    REG_END_Y      = 3'd3,
    REG_NEAR_COLOR = 3'd4,
    REG_FAR_COLOR  = 3'd5,
    REG_USE_SEL    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [PIX_W-1:0]          near_color;
    logic [PIX_W-1:0]          far_color;
    logic                      use_selection;
  } cfg_t;

  // What travels alongside the position arithmetic.
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [CHAN_W-1:0] coverage;
    logic              pass;
    logic              t_zero;
    logic              t_one;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [LEN_W-1:0] den;
    logic [LEN_W-1:0] rem;
    logic [T_W-1:0]   low;
    logic [T_W-1:0]   quo;
  } div_stage_t;

endpackage

`default_nettype wire

@@ src/lgpb_setup.sv @@
// Front of the pipeline: offsets, the four products, their sums and the clamp decision.
// Produces the dividend and divisor for lgpb_div; uses lgpb_pkg.
`default_nettype none

module lgpb_setup (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire lgpb_pkg::cfg_t                       cfg,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [lgpb_pkg::COORD_W-1:0]  canvas_x,
  input  wire logic signed [lgpb_pkg::COORD_W-1:0]  canvas_y,
  input  wire logic [lgpb_pkg::PIX_W-1:0]           pixel,
  input  wire logic                                 inside_selection,
  input  wire logic [lgpb_pkg::CHAN_W-1:0]          coverage,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output lgpb_pkg::side_t                           out_side,
  output logic [lgpb_pkg::LEN_W-1:0]                out_den,
  output logic [lgpb_pkg::DVD_W-1:0]                out_dvd
);

  logic s1_v, s2_v, s3_v, s4_v;
  logic s1_en, s2_en, s3_en, s4_en;

  logic signed [lgpb_pkg::DIFF_W-1:0] rx_now, ry_now, dx_now, dy_now;
  logic                               pass_now;

  logic signed [lgpb_pkg::DIFF_W-1:0] s1_rx, s1_ry, s1_dx, s1_dy;
  lgpb_pkg::side_t                    s1_side;

  logic signed [lgpb_pkg::PROD_W-1:0] s2_pxx, s2_pyy, s2_pnx, s2_pny;
  lgpb_pkg::side_t                    s2_side;

  logic signed [lgpb_pkg::PROD_W-1:0] len_sum;
  logic [lgpb_pkg::LEN_W-1:0]         s3_len2;
  logic signed [lgpb_pkg::NUM_W-1:0]  s3_num;
  lgpb_pkg::side_t                    s3_side;

  logic                               t_zero_now, t_one_now;
  logic [lgpb_pkg::DVD_W-1:0]         dvd_now;

  // A stage moves on when it is empty or the stage after it moves on.
  assign s4_en    = ~s4_v | out_ready;
  assign s3_en    = ~s3_v | s4_en;
  assign s2_en    = ~s2_v | s3_en;
  assign s1_en    = ~s1_v | s2_en;
  assign in_ready = s1_en;

  always_comb begin
    rx_now = $signed({canvas_x[lgpb_pkg::COORD_W-1], canvas_x})
           - $signed({cfg.start_x[lgpb_pkg::COORD_W-1], cfg.start_x});
    ry_now = $signed({canvas_y[lgpb_pkg::COORD_W-1], canvas_y})
           - $signed({cfg.start_y[lgpb_pkg::COORD_W-1], cfg.start_y});
    dx_now = $signed({cfg.end_x[lgpb_pkg::COORD_W-1], cfg.end_x})
           - $signed({cfg.start_x[lgpb_pkg::COORD_W-1], cfg.start_x});
    dy_now = $signed({cfg.end_y[lgpb_pkg::COORD_W-1], cfg.end_y})
           - $signed({cfg.start_y[lgpb_pkg::COORD_W-1], cfg.start_y});
    pass_now = (cfg.start_x == cfg.end_x && cfg.start_y == cfg.end_y)
            || (cfg.use_selection && (!inside_selection || coverage == '0));
  end

  assign len_sum = s2_pxx + s2_pyy;

  always_comb begin
    t_zero_now = s3_num[lgpb_pkg::NUM_W-1] || (s3_num == '0);
    t_one_now  = s3_num >= $signed({1'b0, s3_len2});
    dvd_now    = {1'b0, s3_num[lgpb_pkg::LEN_W-1:0], {lgpb_pkg::POS_FRAC_BITS{1'b0}}}
               + lgpb_pkg::DVD_W'(s3_len2 >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      if (s1_en) s1_v <= in_valid;
      if (s2_en) s2_v <= s1_v;
      if (s3_en) s3_v <= s2_v;
      if (s4_en) s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_rx           <= rx_now;
      s1_ry           <= ry_now;
      s1_dx           <= dx_now;
      s1_dy           <= dy_now;
      s1_side.pixel    <= pixel;
      s1_side.coverage <= coverage;
      s1_side.pass     <= pass_now;
      s1_side.t_zero   <= 1'b0;
      s1_side.t_one    <= 1'b0;
    end
    if (s2_en) begin
      s2_pxx  <= s1_dx * s1_dx;
      s2_pyy  <= s1_dy * s1_dy;
      s2_pnx  <= s1_rx * s1_dx;
      s2_pny  <= s1_ry * s1_dy;
      s2_side <= s1_side;
    end
    if (s3_en) begin
      s3_len2 <= len_sum[lgpb_pkg::LEN_W-1:0];
      s3_num  <= s2_pnx + s2_pny;
      s3_side <= s2_side;
    end
    if (s4_en) begin
      out_side.pixel    <= s3_side.pixel;
      out_side.coverage <= s3_side.coverage;
      out_side.pass     <= s3_side.pass;
      out_side.t_zero   <= t_zero_now;
      out_side.t_one    <= t_one_now;
      out_den           <= s3_len2;
      out_dvd           <= dvd_now;
    end
  end

  assign out_valid = s4_v;

endmodule

`default_nettype wire

@@ src/lgpb_div.sv @@
// Pipelined restoring divider for the gradient position, one quotient bit per stage.
// Takes the dividend and squared length from lgpb_setup; uses lgpb_pkg.
`default_nettype none

module lgpb_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lgpb_pkg::side_t                  in_side,
  input  wire logic [lgpb_pkg::LEN_W-1:0]       in_den,
  input  wire logic [lgpb_pkg::DVD_W-1:0]       in_dvd,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lgpb_pkg::side_t                       out_side,
  output logic [lgpb_pkg::T_W-1:0]              out_quo
);

  localparam int NST = lgpb_pkg::T_W;

  lgpb_pkg::div_stage_t st  [NST];
  lgpb_pkg::div_stage_t din [NST];
  logic                 v   [NST];
  logic                 vin [NST];
  logic                 en  [NST];

  // The top part of the dividend is below the divisor, so it seeds the remainder.
  lgpb_pkg::div_stage_t seed;

  always_comb begin
    seed.side = in_side;
    seed.den  = in_den;
    seed.rem  = in_dvd[lgpb_pkg::DVD_W-1:lgpb_pkg::T_W];
    seed.low  = in_dvd[lgpb_pkg::T_W-1:0];
    seed.quo  = '0;
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [lgpb_pkg::LEN_W:0]   trial;
    logic [lgpb_pkg::LEN_W:0]   diff;
    logic                       ge;

    if (k == NST - 1) begin : g_last
      assign en[k] = ~v[k] | out_ready;
    end else begin : g_mid
      assign en[k] = ~v[k] | en[k+1];
    end

    if (k == 0) begin : g_first
      assign din[k] = seed;
      assign vin[k] = in_valid;
    end else begin : g_next
      assign din[k] = st[k-1];
      assign vin[k] = v[k-1];
    end

    assign trial = {din[k].rem, din[k].low[NST-1-k]};
    assign diff  = trial - {1'b0, din[k].den};
    assign ge    = trial >= {1'b0, din[k].den};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k].side <= din[k].side;
        st[k].den  <= din[k].den;
        st[k].low  <= din[k].low;
        st[k].rem  <= ge ? diff[lgpb_pkg::LEN_W-1:0] : trial[lgpb_pkg::LEN_W-1:0];
        st[k].quo  <= {din[k].quo[NST-2:0], ge};
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];
  assign out_side  = st[NST-1].side;
  assign out_quo   = st[NST-1].quo;

endmodule

`default_nettype wire

@@ src/lgpb_blend.sv @@
// Back of the pipeline: colour interpolation, coverage mix, divide by 255 and output register.
// Takes the position from lgpb_div and the colours from the register file; uses lgpb_pkg.
`default_nettype none

module lgpb_blend (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lgpb_pkg::cfg_t                   cfg,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lgpb_pkg::side_t                  in_side,
  input  wire logic [lgpb_pkg::T_W-1:0]         in_quo,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [lgpb_pkg::PIX_W-1:0]            out_pixel,
  output logic                                  out_modified
);

  logic b1_v, b2_v, b3_v, b4_v;
  logic b1_en, b2_en, b3_en, b4_en;

  logic [lgpb_pkg::T_W-1:0]            t_sel;
  logic signed [lgpb_pkg::CHAN_W:0]    fdiff    [4];
  logic signed [lgpb_pkg::GS_W-1:0]    prod_now [4];
  logic signed [lgpb_pkg::GS_W-1:0]    gsum     [4];
  logic [lgpb_pkg::MIX_W-1:0]          mix_now  [4];
  logic [lgpb_pkg::MIX_W:0]            dq       [4];
  logic [lgpb_pkg::PIX_W-1:0]          res_now;

  logic signed [lgpb_pkg::GS_W-1:0]    b1_prod  [4];
  lgpb_pkg::side_t                     b1_side;
  logic [lgpb_pkg::CHAN_W-1:0]         b2_g     [4];
  lgpb_pkg::side_t                     b2_side;
  logic [lgpb_pkg::CHAN_W-1:0]         b3_g     [4];
  logic [lgpb_pkg::MIX_W-1:0]          b3_mix   [4];
  lgpb_pkg::side_t                     b3_side;

  assign b4_en    = ~b4_v | out_ready;
  assign b3_en    = ~b3_v | b4_en;
  assign b2_en    = ~b2_v | b3_en;
  assign b1_en    = ~b1_v | b2_en;
  assign in_ready = b1_en;

  always_comb begin
    priority if (in_side.t_zero) begin
      t_sel = '0;
    end else if (in_side.t_one) begin
      t_sel = lgpb_pkg::T_ONE;
    end else begin
      t_sel = in_quo;
    end
  end

  // near*(1-t) + far*t is taken as near + (far-near)*t, one multiplier per channel.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      fdiff[c]    = $signed({1'b0, cfg.far_color[8*c +: 8]})
                  - $signed({1'b0, cfg.near_color[8*c +: 8]});
      prod_now[c] = fdiff[c] * $signed({1'b0, t_sel});
      gsum[c]     = $signed({3'b000, cfg.near_color[8*c +: 8],
                             {lgpb_pkg::POS_FRAC_BITS{1'b0}}})
                  + b1_prod[c] + lgpb_pkg::G_HALF;
      mix_now[c]  = ({8'd0, b2_g[c]} * {8'd0, b2_side.coverage})
                  + ({8'd0, b2_side.pixel[8*c +: 8]}
                     * {8'd0, lgpb_pkg::CHAN_MAX - b2_side.coverage})
                  + lgpb_pkg::MIX_BIAS;
      // Exact division by 255 for any value up to 65534, which covers the largest mix.
      dq[c]       = {1'b0, b3_mix[c]} + 17'd1 + {9'd0, b3_mix[c][15:8]};
      res_now[8*c +: 8] = cfg.use_selection ? dq[c][15:8] : b3_g[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
    end else begin
      if (b1_en) b1_v <= in_valid;
      if (b2_en) b2_v <= b1_v;
      if (b3_en) b3_v <= b2_v;
      if (b4_en) b4_v <= b3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_en) begin
      b1_prod <= prod_now;
      b1_side <= in_side;
    end
    if (b2_en) begin
      for (int c = 0; c < 4; c++) begin
        b2_g[c] <= gsum[c][lgpb_pkg::POS_FRAC_BITS +: lgpb_pkg::CHAN_W];
      end
      b2_side <= b1_side;
    end
    if (b3_en) begin
      b3_g    <= b2_g;
      b3_mix  <= mix_now;
      b3_side <= b2_side;
    end
    if (b4_en) begin
      out_pixel    <= b3_side.pass ? b3_side.pixel : res_now;
      out_modified <= ~b3_side.pass;
    end
  end

  assign out_valid = b4_v;

endmodule

`default_nettype wire

@@ src/linear_gradient_pixel_blend.sv @@
// Top level of the linear gradient pixel blend: register file and the three pipeline parts.
// Instantiates lgpb_setup, lgpb_div and lgpb_blend; uses lgpb_pkg.
`default_nettype none

// Takes one pixel a cycle unless the output stalls, and returns it with the gradient colour
// blended over it, in order. The middle part is the position divider, which resolves one
// quotient bit in each stage. Every stage has its own valid bit and moves on when the stage
// after it has room, so a stalled output only stops the input once all stages are full, and
// bubbles close up meanwhile.
// Registers are written through cfg_we/cfg_index/cfg_data and should change only while no
// pixel is in flight; an index beyond the last register is ignored.
module linear_gradient_pixel_blend (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // canvas_x[15:0], canvas_y[31:16], in_red[39:32], in_green[47:40],
  // in_blue[55:48], in_alpha[63:56], coverage[71:64]
  input  wire logic [71:0]                         s_tdata,
  // inside_selection
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [31:0]                              m_tdata,
  // modified
  output logic                                     m_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [lgpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lgpb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lgpb_pkg::cfg_t  cfg;

  logic                          su_valid, su_ready;
  lgpb_pkg::side_t               su_side;
  logic [lgpb_pkg::LEN_W-1:0]    su_den;
  logic [lgpb_pkg::DVD_W-1:0]    su_dvd;

  logic                          dv_valid, dv_ready;
  lgpb_pkg::side_t               dv_side;
  logic [lgpb_pkg::T_W-1:0]      dv_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (lgpb_pkg::cfg_reg_t'(cfg_index))
        lgpb_pkg::REG_START_X:    cfg.start_x       <= cfg_data[lgpb_pkg::COORD_W-1:0];
        lgpb_pkg::REG_START_Y:    cfg.start_y       <= cfg_data[lgpb_pkg::COORD_W-1:0];
        lgpb_pkg::REG_END_X:      cfg.end_x         <= cfg_data[lgpb_pkg::COORD_W-1:0];
        lgpb_pkg::REG_END_Y:      cfg.end_y         <= cfg_data[lgpb_pkg::COORD_W-1:0];
        lgpb_pkg::REG_NEAR_COLOR: cfg.near_color    <= cfg_data[lgpb_pkg::PIX_W-1:0];
        lgpb_pkg::REG_FAR_COLOR:  cfg.far_color     <= cfg_data[lgpb_pkg::PIX_W-1:0];
        lgpb_pkg::REG_USE_SEL:    cfg.use_selection <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  lgpb_setup u_setup (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .canvas_x         ($signed(s_tdata[15:0])),
    .canvas_y         ($signed(s_tdata[31:16])),
    .pixel            (s_tdata[63:32]),
    .inside_selection (s_tuser),
    .coverage         (s_tdata[71:64]),
    .out_valid        (su_valid),
    .out_ready        (su_ready),
    .out_side         (su_side),
    .out_den          (su_den),
    .out_dvd          (su_dvd)
  );

  lgpb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (su_valid),
    .in_ready  (su_ready),
    .in_side   (su_side),
    .in_den    (su_den),
    .in_dvd    (su_dvd),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_side  (dv_side),
    .out_quo   (dv_quo)
  );

  lgpb_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (dv_valid),
    .in_ready     (dv_ready),
    .in_side      (dv_side),
    .in_quo       (dv_quo),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_pixel    (m_tdata),
    .out_modified (m_tuser)
  );

endmodule

`default_nettype wire

@@ src/lgpb_checker.sv @@
// Port-level checks for the gradient blend block, attached to the top level by bind.
// Uses lgpb_pkg and the macros in assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lgpb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser
);

  localparam int CNT_W = $clog2(lgpb_pkg::PIPE_DEPTH + 2);

  logic [CNT_W-1:0] inflight;
  logic             s_acc, m_acc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  // Words taken in and not yet handed out.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(s_acc) - CNT_W'(m_acc);
    end
  end

  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid right after reset")

  `CHK_ASSERT(a_hold_stalled, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output word changed")

  `CHK_ASSERT(a_no_phantom, clk, rst, m_tvalid |-> inflight != '0 && inflight <= CNT_W'(lgpb_pkg::PIPE_DEPTH), "output word without a matching input word")

  `CHK_ASSERT(a_ready_when_empty, clk, rst, inflight == '0 |-> s_tready, "input not ready with an empty pipeline")

endmodule

bind linear_gradient_pixel_blend lgpb_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for linear_gradient_pixel_blend: directed pixels, then random ones.
// It predicts every blended word from its own copy of the registers and checks the stream.
// Depends on lgpb_pkg and the RTL of the block only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lgpb_pkg::*;

  // No register sits behind this index, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int LIMIT_NS = 20_000_000;
  localparam int PIXELS_PER_GRADIENT = 150;

  // Packed as on s_tdata: x in the lowest bits, coverage in the highest.
  typedef struct packed {
    logic [7:0]         coverage;
    logic [31:0]        rgba;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } pixel_word_t;

  typedef struct packed {
    logic        modified;
    logic [31:0] rgba;
  } blend_word_t;

  typedef enum {SPAN_FULL, SPAN_LOCAL, SPAN_EDGE} span_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [71:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t        gradient_regs = '0;
  blend_word_t expected_pixels[$];
  blend_word_t want_pixel;
  int          mismatch_count = 0;
  int          ch;
  bit          sender_steady = 1'b0;
  bit          sink_steady = 1'b0;
  string       channel_names[4] = '{"red", "green", "blue", "alpha"};

  linear_gradient_pixel_blend DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic pixel_word_t make_pixel(logic signed [15:0] x, logic signed [15:0] y,
                                             logic [31:0] rgba, logic [7:0] coverage);
    pixel_word_t p;
    p.x = x;
    p.y = y;
    p.rgba = rgba;
    p.coverage = coverage;
    return p;
  endfunction

  function automatic logic signed [15:0] rand_coord(span_t span);
    int v;
    case (span)
      SPAN_LOCAL: begin
        v = int'($urandom_range(128, 0)) - 64;
        return v[15:0];
      end
      SPAN_EDGE: return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // A coordinate within the bounding box of the line, with a small margin.
  function automatic logic signed [15:0] pick_near(logic signed [15:0] a, logic signed [15:0] b);
    int lo, hi, v;
    lo = ((a < b) ? a : b) - 16;
    hi = ((a < b) ? b : a) + 16;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    v = lo + int'($urandom_range(hi - lo, 0));
    return v[15:0];
  endfunction

  // Expected word for one pixel under the current register settings.
  function automatic blend_word_t blend_pixel(pixel_word_t p, logic in_sel);
    longint one, sx, sy, dx, dy, len2, num, t, near_c, far_c, mix, cov;
    int c;
    blend_word_t r;
    one = longint'(1) << POS_FRAC_BITS;
    sx = longint'($signed(gradient_regs.start_x));
    sy = longint'($signed(gradient_regs.start_y));
    dx = longint'($signed(gradient_regs.end_x)) - sx;
    dy = longint'($signed(gradient_regs.end_y)) - sy;
    len2 = dx * dx + dy * dy;
    cov = longint'(p.coverage);
    r.rgba = p.rgba;
    r.modified = 1'b0;
    if (len2 == 0 || (gradient_regs.use_selection && (!in_sel || p.coverage == 8'd0)))
      return r;
    num = (longint'($signed(p.x)) - sx) * dx + (longint'($signed(p.y)) - sy) * dy;
    if (num <= 0)
      t = 0;
    else if (num >= len2)
      t = one;
    else
      t = ((num << POS_FRAC_BITS) + (len2 >>> 1)) / len2;
    for (c = 0; c < 4; c++) begin
      near_c = longint'(gradient_regs.near_color[8*c +: 8]);
      far_c = longint'(gradient_regs.far_color[8*c +: 8]);
      mix = (near_c * (one - t) + far_c * t + (one >>> 1)) >>> POS_FRAC_BITS;
      if (gradient_regs.use_selection)
        mix = (mix * cov + longint'(p.rgba[8*c +: 8]) * (255 - cov) + 127) / 255;
      r.rgba[8*c +: 8] = mix[7:0];
    end
    r.modified = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic send_pixel(pixel_word_t p, logic in_sel);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    s_tuser <= in_sel;
    do @(posedge clk); while (!s_tready);
    expected_pixels.push_back(blend_pixel(p, in_sel));
  endtask

  // Stops sending and waits until every expected word has come out.
  task automatic drain_pixels(int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_START_X:    gradient_regs.start_x = value[15:0];
      REG_START_Y:    gradient_regs.start_y = value[15:0];
      REG_END_X:      gradient_regs.end_x = value[15:0];
      REG_END_Y:      gradient_regs.end_y = value[15:0];
      REG_NEAR_COLOR: gradient_regs.near_color = value;
      REG_FAR_COLOR:  gradient_regs.far_color = value;
      REG_USE_SEL:    gradient_regs.use_selection = value[0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the narrow registers carry noise; they must be ignored.
  task automatic program_gradient(cfg_t c, bit stray);
    drain_pixels(0);
    write_reg(REG_START_X, {16'($urandom()), c.start_x});
    write_reg(REG_START_Y, {16'($urandom()), c.start_y});
    write_reg(REG_END_X, {16'($urandom()), c.end_x});
    write_reg(REG_END_Y, {16'($urandom()), c.end_y});
    write_reg(REG_NEAR_COLOR, c.near_color);
    write_reg(REG_FAR_COLOR, c.far_color);
    write_reg(REG_USE_SEL, {31'($urandom()), c.use_selection});
    if (stray) write_reg(REG_NONE, $urandom());
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // All registers are zero after reset, so the line has no length and pixels pass.
  task automatic test_reset_passthrough();
    send_pixel(make_pixel(16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF, 8'hFF), 1'b1);
    send_pixel(make_pixel(16'sh0000, 16'sh0000, 32'h0000_0000, 8'h00), 1'b0);
  endtask

  task automatic test_gradient_ends();
    cfg_t c;
    c = '{start_x: 16'sh8000, start_y: 16'sh8000, end_x: 16'sh7FFF, end_y: 16'sh7FFF,
          near_color: 32'h0000_0000, far_color: 32'hFFFF_FFFF, use_selection: 1'b0};
    program_gradient(c, 1'b0);
    // Selection is off, so the flag and coverage below must make no difference.
    send_pixel(make_pixel(16'sh8000, 16'sh8000, 32'h1234_5678, 8'h00), 1'b0);
    send_pixel(make_pixel(16'sh7FFF, 16'sh7FFF, 32'h8765_4321, 8'h00), 1'b0);
    send_pixel(make_pixel(16'sh0000, 16'sh0000, 32'hFFFF_FFFF, 8'h7F), 1'b1);
    // Exactly half way along, which exercises the rounding of a half.
    send_pixel(make_pixel(16'sh8000, 16'sh7FFF, 32'h0000_0000, 8'hFF), 1'b0);
  endtask

  task automatic test_selection_weighting();
    cfg_t c;
    c = '{start_x: -16'sd100, start_y: 16'sd50, end_x: 16'sd200, end_y: 16'sd50,
          near_color: 32'h80FF_0010, far_color: 32'h01FE_7FEF, use_selection: 1'b1};
    program_gradient(c, 1'b1);
    send_pixel(make_pixel(16'sh8000, 16'sh0000, 32'hFFFF_FFFF, 8'hFF), 1'b1);
    send_pixel(make_pixel(16'sh7FFF, 16'sh7FFF, 32'h0000_0000, 8'h80), 1'b1);
    send_pixel(make_pixel(16'sd50, 16'sh8000, 32'hA5A5_5A5A, 8'h01), 1'b1);
    send_pixel(make_pixel(16'sd50, 16'sd50, 32'h1234_5678, 8'hC0), 1'b0);
    send_pixel(make_pixel(16'sd60, 16'sd50, 32'h8765_4321, 8'h00), 1'b1);
    send_pixel(make_pixel(-16'sd99, 16'sd49, 32'h00FF_FF00, 8'hFE), 1'b1);
  endtask

  task automatic test_degenerate_line();
    cfg_t c;
    c = '{start_x: 16'sh7FFF, start_y: 16'sh8000, end_x: 16'sh7FFF, end_y: 16'sh8000,
          near_color: 32'hDEAD_BEEF, far_color: 32'h0BAD_F00D, use_selection: 1'b0};
    program_gradient(c, 1'b0);
    send_pixel(make_pixel(16'sh7FFF, 16'sh8000, 32'h5555_AAAA, 8'hFF), 1'b1);
    send_pixel(make_pixel(16'sh0001, 16'sh7FFE, 32'hAAAA_5555, 8'h10), 1'b1);
  endtask

  task automatic test_vertical_line();
    cfg_t c;
    c = '{start_x: 16'sh0000, start_y: 16'sh8000, end_x: 16'sh0000, end_y: 16'sh7FFF,
          near_color: 32'hFF00_FF00, far_color: 32'h00FF_00FF, use_selection: 1'b0};
    program_gradient(c, 1'b0);
    send_pixel(make_pixel(16'sd12345, 16'sh0000, 32'h0F0F_0F0F, 8'h33), 1'b0);
    send_pixel(make_pixel(16'sh8000, -16'sd16384, 32'hF0F0_F0F0, 8'hCC), 1'b1);
  endtask

  // Random gradients, each followed by a batch of pixels mostly placed along its line.
  task automatic test_random_gradients(int total);
    cfg_t c;
    int phases, ph, i, pick;
    span_t span;
    pixel_word_t p;
    phases = (total + PIXELS_PER_GRADIENT - 1) / PIXELS_PER_GRADIENT;
    for (ph = 0; ph < phases; ph++) begin
      span = span_t'($urandom_range(2, 0));
      c.start_x = rand_coord(span);
      c.start_y = rand_coord(span);
      c.end_x = rand_coord(span);
      c.end_y = rand_coord(span);
      if (ph % 6 == 3) begin
        c.end_x = c.start_x;
        c.end_y = c.start_y;
      end
      c.near_color = $urandom();
      c.far_color = $urandom();
      c.use_selection = (ph % 3 != 0);
      sender_steady = (ph % 4 == 1);
      sink_steady = (ph % 4 == 1) || (ph % 4 == 2);
      program_gradient(c, ph % 5 == 0);
      for (i = 0; i < PIXELS_PER_GRADIENT; i++) begin
        // Once, let the pipeline run empty before carrying on.
        if (ph == 2 && i == PIXELS_PER_GRADIENT / 2) drain_pixels(0);
        if ($urandom_range(4, 0) == 0) begin
          p.x = 16'($urandom());
          p.y = 16'($urandom());
        end else begin
          p.x = pick_near(c.start_x, c.end_x);
          p.y = pick_near(c.start_y, c.end_y);
        end
        p.rgba = $urandom();
        pick = $urandom_range(99, 0);
        p.coverage = (pick < 12) ? 8'h00 : (pick < 24) ? 8'hFF : 8'($urandom());
        send_pixel(p, $urandom_range(99, 0) < 85);
      end
    end
    sender_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Output back-pressure: runs of ready broken by stalls of random length.
  initial begin
    int run, stall;
    wait (rst === 1'b0);
    forever begin
      m_tready <= 1'b1;
      run = $urandom_range(24, 1);
      repeat (run) @(posedge clk);
      stall = sink_steady ? 0 : pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, '0);
      end else begin
        want_pixel = expected_pixels.pop_front();
        for (ch = 0; ch < 4; ch++)
          if (m_tdata[8*ch +: 8] !== want_pixel.rgba[8*ch +: 8])
            report_mismatch(channel_names[ch], m_tdata[8*ch +: 8], want_pixel.rgba[8*ch +: 8]);
        if (m_tuser !== want_pixel.modified)
          report_mismatch("modified", m_tuser, want_pixel.modified);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_passthrough();
    test_gradient_ends();
    test_selection_weighting();
    test_degenerate_line();
    test_vertical_line();
    test_random_gradients(1935);
    drain_pixels(PIPE_DEPTH + 8);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
